### sv/pln_pkg.sv
// Package for the periodic lattice neighbour core.
// Holds field widths, register indexes, divider pipeline constants and the geometry struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pln_pkg;

  // Fixed field widths.
  localparam int SITE_W    = 24;
  localparam int EDGE_W    = 9;
  localparam int DIM_W     = 2;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 3'd3;

  // Dimension codes.
  localparam logic [DIM_W-1:0] DIM_1D = 2'd1;
  localparam logic [DIM_W-1:0] DIM_2D = 2'd2;
  localparam logic [DIM_W-1:0] DIM_3D = 2'd3;

  // Restoring divider: quotient bits resolved per pipeline stage.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = SITE_W / DIV_STEPS;

  // Lattice offsets derived from the edge lengths, all modulo 2^SITE_W.
  typedef struct packed {
    logic [DIM_W-1:0]  dim;     // dimension, zero already mapped to one
    logic [SITE_W-1:0] wrap_x;  // nx - 1
    logic [SITE_W-1:0] step_y;  // nx
    logic [SITE_W-1:0] wrap_y;  // nx * (ny - 1)
    logic [SITE_W-1:0] step_z;  // nx * ny
    logic [SITE_W-1:0] wrap_z;  // nx * ny * (nz - 1)
  } nbr_geom_t;

endpackage

`default_nettype wire

### sv/pln_geom.sv
// Geometry unit: turns the clamped edge lengths into the neighbour offsets.
// Two register stages, two multipliers in the first and one in the second. Depends on pln_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pln_geom import pln_pkg::*; #(
  parameter int CW = 9
) (
  input  wire logic              clk,
  input  wire logic [CW-1:0]     nx,
  input  wire logic [CW-1:0]     ny,
  input  wire logic [CW-1:0]     nz,
  input  wire logic [DIM_W-1:0]  dim,
  output nbr_geom_t              geom
);

  localparam int PW1 = 2 * CW;
  localparam int PW2 = SITE_W + CW;

  logic [SITE_W-1:0] plane_r, plane_nxt;
  logic [SITE_W-1:0] wrap_y_r, wrap_y_nxt;
  logic [CW-1:0]     nx_r, nz1_r;
  logic [DIM_W-1:0]  dim_r;
  nbr_geom_t         geom_r, geom_nxt;
  logic [PW1-1:0]    prod_plane, prod_wrap_y;
  logic [PW2-1:0]    prod_wrap_z;

  // First stage: the plane size and the y wrap distance.
  always_comb begin
    prod_plane  = PW1'(nx) * PW1'(ny);
    prod_wrap_y = PW1'(nx) * PW1'(ny - CW'(1));
    plane_nxt   = SITE_W'(prod_plane);
    wrap_y_nxt  = SITE_W'(prod_wrap_y);
  end

  // Second stage: the z wrap distance from the registered plane size.
  always_comb begin
    prod_wrap_z     = PW2'(plane_r) * PW2'(nz1_r);
    geom_nxt.dim    = dim_r;
    geom_nxt.wrap_x = SITE_W'(nx_r) - SITE_W'(1);
    geom_nxt.step_y = SITE_W'(nx_r);
    geom_nxt.wrap_y = wrap_y_r;
    geom_nxt.step_z = plane_r;
    geom_nxt.wrap_z = SITE_W'(prod_wrap_z);
  end

  always_ff @(posedge clk) begin
    plane_r  <= plane_nxt;
    wrap_y_r <= wrap_y_nxt;
    nx_r     <= nx;
    nz1_r    <= nz - CW'(1);
    dim_r    <= dim;
    geom_r   <= geom_nxt;
  end

  assign geom = geom_r;

endmodule

`default_nettype wire

### sv/pln_div.sv
// Pipelined restoring divider of a site-wide dividend by a narrow divisor.
// DIV_STEPS quotient bits per stage, a sideband word travels with each request.
// Depends on pln_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pln_div import pln_pkg::*; #(
  parameter int DW  = 9,
  parameter int SBW = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [SITE_W-1:0] in_dividend,
  input  wire logic [DW-1:0]     in_divisor,
  input  wire logic [SBW-1:0]    in_sb,
  output logic                   out_valid,
  output logic [SITE_W-1:0]      out_quot,
  output logic [DW-1:0]          out_rem,
  output logic [SBW-1:0]         out_sb
);

  logic              valid_r   [DIV_STAGES];
  logic [DW-1:0]     rem_r     [DIV_STAGES];
  logic [SITE_W-1:0] dq_r      [DIV_STAGES];
  logic [SBW-1:0]    sb_r      [DIV_STAGES];
  logic              valid_nxt [DIV_STAGES];
  logic [DW-1:0]     rem_nxt   [DIV_STAGES];
  logic [SITE_W-1:0] dq_nxt    [DIV_STAGES];
  logic [SBW-1:0]    sb_nxt    [DIV_STAGES];

  // The dividend register shifts left: its top bit moves into the partial
  // remainder and the new quotient bit enters at the bottom.
  always_comb begin
    logic [DW:0]       trial;
    logic [DW-1:0]     rem_v;
    logic [SITE_W-1:0] dq_v;
    trial = '0;
    rem_v = '0;
    dq_v  = '0;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        valid_nxt[s] = in_valid;
        sb_nxt[s]    = in_sb;
        rem_v        = '0;
        dq_v         = in_dividend;
      end else begin
        valid_nxt[s] = valid_r[s-1];
        sb_nxt[s]    = sb_r[s-1];
        rem_v        = rem_r[s-1];
        dq_v         = dq_r[s-1];
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {rem_v, dq_v[SITE_W-1]};
        dq_v  = {dq_v[SITE_W-2:0], 1'b0};
        if (trial >= {1'b0, in_divisor}) begin
          trial   = trial - {1'b0, in_divisor};
          dq_v[0] = 1'b1;
        end
        rem_v = trial[DW-1:0];
      end
      rem_nxt[s] = rem_v;
      dq_nxt[s]  = dq_v;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else begin
        valid_r[s] <= valid_nxt[s];
      end
      rem_r[s] <= rem_nxt[s];
      dq_r[s]  <= dq_nxt[s];
      sb_r[s]  <= sb_nxt[s];
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_quot  = dq_r[DIV_STAGES-1];
  assign out_rem   = rem_r[DIV_STAGES-1];
  assign out_sb    = sb_r[DIV_STAGES-1];

  // A finished remainder is always below the divisor.
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rem < in_divisor))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

### sv/pln_nbr.sv
// Neighbour stage: forms the six wrapped neighbour indices from the site and
// its coordinates and registers the result. Depends on pln_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pln_nbr import pln_pkg::*; #(
  parameter int DW = 9
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [SITE_W-1:0] in_site,
  input  wire logic [DW-1:0]     in_x,
  input  wire logic [DW-1:0]     in_y,
  input  wire logic [SITE_W-1:0] in_z,
  input  wire logic [DW-1:0]     nx,
  input  wire logic [DW-1:0]     ny,
  input  wire logic [DW-1:0]     nz,
  input  wire nbr_geom_t         geom,
  output logic                   out_valid,
  output logic [SITE_W-1:0]      out_left,
  output logic [SITE_W-1:0]      out_right,
  output logic [SITE_W-1:0]      out_up,
  output logic [SITE_W-1:0]      out_down,
  output logic [SITE_W-1:0]      out_front,
  output logic [SITE_W-1:0]      out_back,
  output logic                   out_in_range
);

  logic              valid_r;
  logic [SITE_W-1:0] left_r, right_r, up_r, down_r, front_r, back_r;
  logic [SITE_W-1:0] left_nxt, right_nxt, up_nxt, down_nxt, front_nxt, back_nxt;
  logic              in_range_r, in_range_nxt;
  logic              x_lo, x_hi, y_lo, y_hi, z_lo, z_hi, use_y, use_z;

  // The site already holds z*plane + y*nx + x, so each neighbour is the site
  // plus or minus one step, or the opposite wrap distance at an edge.
  always_comb begin
    in_range_nxt = in_z < SITE_W'(nz);
    x_lo  = in_x == '0;
    x_hi  = in_x == nx - DW'(1);
    y_lo  = in_y == '0;
    y_hi  = in_y == ny - DW'(1);
    z_lo  = in_z == '0;
    z_hi  = in_z == SITE_W'(nz) - SITE_W'(1);
    use_y = in_range_nxt && (geom.dim == DIM_2D || geom.dim == DIM_3D);
    use_z = in_range_nxt && (geom.dim == DIM_3D);

    left_nxt  = x_lo ? in_site + geom.wrap_x : in_site - SITE_W'(1);
    right_nxt = x_hi ? in_site - geom.wrap_x : in_site + SITE_W'(1);
    up_nxt    = y_lo ? in_site + geom.wrap_y : in_site - geom.step_y;
    down_nxt  = y_hi ? in_site - geom.wrap_y : in_site + geom.step_y;
    front_nxt = z_lo ? in_site + geom.wrap_z : in_site - geom.step_z;
    back_nxt  = z_hi ? in_site - geom.wrap_z : in_site + geom.step_z;

    if (!in_range_nxt) begin
      left_nxt  = '0;
      right_nxt = '0;
    end
    if (!use_y) begin
      up_nxt   = '0;
      down_nxt = '0;
    end
    if (!use_z) begin
      front_nxt = '0;
      back_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    up_r       <= up_nxt;
    down_r     <= down_nxt;
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    in_range_r <= in_range_nxt;
  end

  assign out_valid    = valid_r;
  assign out_left     = left_r;
  assign out_right    = right_r;
  assign out_up       = up_r;
  assign out_down     = down_r;
  assign out_front    = front_r;
  assign out_back     = back_r;
  assign out_in_range = in_range_r;

endmodule

`default_nettype wire

### sv/periodic_lattice_neighbours_core.sv
// Top level of the periodic lattice neighbour core: configuration registers,
// two divider pipelines, the geometry unit and the neighbour stage.
// Depends on pln_pkg, pln_geom, pln_div and pln_nbr.
`timescale 1ns / 1ps
`default_nettype none

// Takes one linear site index per clock (start high, busy is always low) and
// returns the six periodic nearest neighbours of that site plus an in_range
// flag, marked by a one-cycle out_valid strobe. Each request passes through
// the two 24-bit restoring dividers (site / size_x, then that quotient /
// size_y), each a six-stage pipeline resolving four quotient bits per stage,
// and then one register for the neighbour adders. Requests
// may follow each other in every cycle; results come out in request order and
// the receiver has no way to hold them off. Edge lengths of zero act as one,
// lengths above MAX_EDGE act as MAX_EDGE, and dimension zero acts as one.
// Configuration must only be written while no request is in flight; a request
// may be issued in the cycle after a write.
module periodic_lattice_neighbours_core import pln_pkg::*; #(
  parameter int MAX_EDGE = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [SITE_W-1:0]    in_site,
  output logic                      out_valid,
  output logic [SITE_W-1:0]         out_left,
  output logic [SITE_W-1:0]         out_right,
  output logic [SITE_W-1:0]         out_up,
  output logic [SITE_W-1:0]         out_down,
  output logic [SITE_W-1:0]         out_front,
  output logic [SITE_W-1:0]         out_back,
  output logic                      out_in_range,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [EDGE_W-1:0]    cfg_data
);

  // Width of a clamped edge length.
  localparam int CW       = $clog2(MAX_EDGE + 1);
  localparam int PIPE_LAT = 2 * DIV_STAGES + 1;

  logic [EDGE_W-1:0] size_x_r, size_y_r, size_z_r;
  logic [DIM_W-1:0]  dim_r;
  logic [CW-1:0]     nx, ny, nz;
  logic [DIM_W-1:0]  dim_c;
  logic              accept;
  nbr_geom_t         geom;

  logic              d1_valid;
  logic [SITE_W-1:0] d1_quot, d1_site;
  logic [CW-1:0]     d1_rem;
  logic              d2_valid;
  logic [SITE_W-1:0] d2_quot, d2_site;
  logic [CW-1:0]     d2_rem, d2_x;

  function automatic logic [CW-1:0] clamp_edge(input logic [EDGE_W-1:0] e);
    if (e == '0) begin
      return CW'(1);
    end else if (int'(e) > MAX_EDGE) begin
      return CW'(MAX_EDGE);
    end else begin
      return CW'(e);
    end
  endfunction

  // The pipeline takes a request in every cycle, so busy never rises.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers. Writes to indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= EDGE_W'(1);
      size_y_r <= EDGE_W'(1);
      size_z_r <= EDGE_W'(1);
      dim_r    <= DIM_1D;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_X:    size_x_r <= cfg_data;
        REG_SIZE_Y:    size_y_r <= cfg_data;
        REG_SIZE_Z:    size_z_r <= cfg_data;
        REG_DIMENSION: dim_r    <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamping is plain logic on the registers, so a request issued right after
  // a write already sees the new edge lengths in the dividers.
  always_comb begin
    nx    = clamp_edge(size_x_r);
    ny    = clamp_edge(size_y_r);
    nz    = clamp_edge(size_z_r);
    dim_c = (dim_r == '0) ? DIM_1D : dim_r;
  end

  // The offsets pass through the geometry unit's registers after a write and
  // settle long before any request reaches the neighbour stage.
  pln_geom #(.CW(CW)) u_geom (
    .clk  (clk),
    .nx   (nx),
    .ny   (ny),
    .nz   (nz),
    .dim  (dim_c),
    .geom (geom)
  );

  // site = q1 * nx + x
  pln_div #(.DW(CW), .SBW(SITE_W)) u_div_x (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (accept),
    .in_dividend (in_site),
    .in_divisor  (nx),
    .in_sb       (in_site),
    .out_valid   (d1_valid),
    .out_quot    (d1_quot),
    .out_rem     (d1_rem),
    .out_sb      (d1_site)
  );

  // q1 = z * ny + y; z is also the site divided by the plane size, which makes
  // it the range check against nz.
  pln_div #(.DW(CW), .SBW(SITE_W + CW)) u_div_y (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (d1_valid),
    .in_dividend (d1_quot),
    .in_divisor  (ny),
    .in_sb       ({d1_site, d1_rem}),
    .out_valid   (d2_valid),
    .out_quot    (d2_quot),
    .out_rem     (d2_rem),
    .out_sb      ({d2_site, d2_x})
  );

  pln_nbr #(.DW(CW)) u_nbr (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (d2_valid),
    .in_site      (d2_site),
    .in_x         (d2_x),
    .in_y         (d2_rem),
    .in_z         (d2_quot),
    .nx           (nx),
    .ny           (ny),
    .nz           (nz),
    .geom         (geom),
    .out_valid    (out_valid),
    .out_left     (out_left),
    .out_right    (out_right),
    .out_up       (out_up),
    .out_down     (out_down),
    .out_front    (out_front),
    .out_back     (out_back),
    .out_in_range (out_in_range)
  );

  // Every accepted request is followed by its result on out_valid.
  a_fixed_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##PIPE_LAT out_valid)
    else $error("result missing after pipeline latency");

  // A site outside the lattice reports no neighbours at all.
  a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |->
      (out_left == '0 && out_right == '0 && out_up == '0 &&
       out_down == '0 && out_front == '0 && out_back == '0))
    else $error("out-of-range site has nonzero neighbours");

  // A one-dimensional lattice has no y or z neighbours.
  a_unused_axes_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && dim_c == DIM_1D) |->
      (out_up == '0 && out_down == '0 && out_front == '0 && out_back == '0))
    else $error("unused axis neighbour is nonzero");

endmodule

`default_nettype wire
